// ----- rtl/pfd_pkg.sv -----
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types, constants and helpers for the playfair digraph cipher block.
// ----------------------------------------------------------------------------
package pfd_pkg;

   localparam int GRID     = 5;
   localparam int PLACES   = 25;
   localparam int LETTERS  = 26;

   localparam logic [4:0] LETTER_I    = 5'd8;
   localparam logic [4:0] LETTER_J    = 5'd9;
   localparam logic [4:0] LAST_LETTER = 5'(LETTERS - 1);
   localparam logic [2:0] LAST_INDEX  = 3'(GRID - 1);
   localparam logic [2:0] GRID_ROWS   = 3'(GRID);

   // command codes of an input beat
   typedef enum logic [1:0] {
      CMD_KEY    = 2'd0,
      CMD_FINISH = 2'd1,
      CMD_PAIR   = 2'd2
   } cmd_code_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [4:0] first_letter;
      logic [4:0] second_letter;
   } req_payload_type;

   typedef struct packed {
      logic [4:0] out_first;
      logic [4:0] out_second;
   } rsp_payload_type;

   // place of a letter in the grid
   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
   } grid_pos_type;

   // controller to datapath
   typedef struct packed {
      logic place_key;
      logic scan_start;
      logic fill_step;
      logic pos_read;
      logic table_read;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic key_ok;
      logic pair_ok;
      logic table_complete;
      logic scan_last;
   } dp_status_type;

   // one step around the grid, forward or back
   function automatic logic [2:0] grid_step(input logic [2:0] v, input logic dec);
      logic [2:0] r;
      if (dec) begin
         r = (v == 3'd0) ? LAST_INDEX : v - 3'd1;
      end else begin
         r = (v == LAST_INDEX) ? 3'd0 : v + 3'd1;
      end
      return r;
   endfunction

   // row * 5 + col
   function automatic logic [4:0] place_addr(input grid_pos_type p);
      return {p.row, 2'b00} + {2'b00, p.row} + {2'b00, p.col};
   endfunction

   // j reads as i
   function automatic logic [4:0] fold_j(input logic [4:0] v);
      return (v == LETTER_J) ? LETTER_I : v;
   endfunction

endpackage

// ----- rtl/pfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfd_ctrl
// Controller: sequences key placement, the finish scan and digraph lookups.
// ----------------------------------------------------------------------------
module pfd_ctrl
   import pfd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [1:0]      req_cmd,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output dp_cmd_type      dp_cmd,
   input  dp_status_type   dp_status
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;

   // state and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      dp_cmd    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_KEY: begin
                     dp_cmd.place_key = dp_status.key_ok;
                  end
                  CMD_FINISH: begin
                     if (!dp_status.table_complete) begin
                        dp_cmd.scan_start = 1'b1;
                        state_in          = ST_SCAN;
                     end
                  end
                  CMD_PAIR: begin
                     if (dp_status.table_complete && dp_status.pair_ok) begin
                        dp_cmd.pos_read = 1'b1;
                        state_in        = ST_LOOKUP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            if (rsp_free) begin
               dp_cmd.table_read = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_SCAN: begin
            dp_cmd.fill_step = 1'b1;
            if (dp_status.scan_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result beat held until taken
   always_comb begin
      if (dp_cmd.table_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

// ----- rtl/pfd_datapath.sv -----
// ----------------------------------------------------------------------------
// pfd_datapath
// Datapath: key table and letter position memories, fill pointer, used
// flags, mode register and the digraph rule logic.
// ----------------------------------------------------------------------------
module pfd_datapath
   import pfd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   input  logic            csr_write,
   input  logic            csr_wdata,
   output rsp_payload_type rsp_payload,
   input  dp_cmd_type      dp_cmd,
   output dp_status_type   dp_status
);

   // memories
   logic [4:0]   key_table [PLACES];
   grid_pos_type letter_pos [LETTERS];

   logic [LETTERS-1:0] used_ff, used_in;
   logic               complete_ff, complete_in;
   logic               decrypt_ff;
   grid_pos_type       fill_ff, fill_in;
   logic [4:0]         scan_ff, scan_in;
   grid_pos_type       pos_a_ff, pos_b_ff;
   rsp_payload_type    rsp_ff;

   logic [4:0]   key_letter, letter_a, letter_b, wr_letter;
   logic         full, scan_ok, wr_en;
   grid_pos_type ta, tb;

   assign full       = (fill_ff.row == GRID_ROWS);
   assign key_letter = req_payload.first_letter;
   assign letter_a   = fold_j(req_payload.first_letter);
   assign letter_b   = fold_j(req_payload.second_letter);

   // status back to the controller
   assign dp_status.key_ok = !complete_ff && !full && (key_letter <= LAST_LETTER)
                             && (key_letter != LETTER_J) && !used_ff[key_letter];
   assign dp_status.pair_ok = (req_payload.first_letter <= LAST_LETTER)
                              && (req_payload.second_letter <= LAST_LETTER);
   assign dp_status.table_complete = complete_ff;
   assign dp_status.scan_last      = (scan_ff == LAST_LETTER);

   // placement source: key beat or finish scan
   assign scan_ok   = (scan_ff != LETTER_J) && !used_ff[scan_ff] && !full;
   assign wr_letter = dp_cmd.place_key ? key_letter : scan_ff;
   assign wr_en     = dp_cmd.place_key || (dp_cmd.fill_step && scan_ok);

   // next values of the control registers
   always_comb begin
      used_in     = used_ff;
      fill_in     = fill_ff;
      complete_in = complete_ff;
      scan_in     = scan_ff;
      if (wr_en) begin
         used_in[wr_letter] = 1'b1;
         if (fill_ff.col == LAST_INDEX) begin
            fill_in.col = 3'd0;
            fill_in.row = fill_ff.row + 3'd1;
         end else begin
            fill_in.col = fill_ff.col + 3'd1;
         end
      end
      if (dp_cmd.scan_start) begin
         scan_in = 5'd0;
      end else if (dp_cmd.fill_step) begin
         scan_in = scan_ff + 5'd1;
      end
      if (dp_cmd.fill_step && dp_status.scan_last) begin
         complete_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         fill_ff     <= '0;
         complete_ff <= 1'b0;
         scan_ff     <= 5'd0;
         decrypt_ff  <= 1'b0;
      end else begin
         used_ff     <= used_in;
         fill_ff     <= fill_in;
         complete_ff <= complete_in;
         scan_ff     <= scan_in;
         if (csr_write) begin
            decrypt_ff <= csr_wdata;
         end
      end
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_table[place_addr(fill_ff)] <= wr_letter;
         letter_pos[wr_letter]          <= fill_ff;
      end
   end

   // position lookup, registered read
   always_ff @(posedge clock) begin
      if (dp_cmd.pos_read) begin
         pos_a_ff <= letter_pos[letter_a];
         pos_b_ff <= letter_pos[letter_b];
      end
   end

   // same row, same column or rectangle
   always_comb begin
      ta = pos_a_ff;
      tb = pos_b_ff;
      if (pos_a_ff.row == pos_b_ff.row) begin
         ta.col = grid_step(pos_a_ff.col, decrypt_ff);
         tb.col = grid_step(pos_b_ff.col, decrypt_ff);
      end else if (pos_a_ff.col == pos_b_ff.col) begin
         ta.row = grid_step(pos_a_ff.row, decrypt_ff);
         tb.row = grid_step(pos_b_ff.row, decrypt_ff);
      end else begin
         ta.col = pos_b_ff.col;
         tb.col = pos_a_ff.col;
      end
   end

   // key table read straight into the result register
   always_ff @(posedge clock) begin
      if (dp_cmd.table_read) begin
         rsp_ff.out_first  <= key_table[place_addr(ta)];
         rsp_ff.out_second <= key_table[place_addr(tb)];
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/playfair_digraph_cipher_top.sv -----
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_top
// Playfair cipher over letter indices: key table build and digraph transform.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries cmd, first_letter, second_letter.
//   A key beat places a new letter other than j in the next free place.
//   A finish beat fills the rest of the grid in alphabet order.
//   A digraph beat, once the grid is complete, yields one rsp beat.
//   csr channel writes decrypt_mode (0 encrypt, 1 decrypt); always ready.
// Sequence:
//   key beat: placed in the cycle it is taken. finish beat: the scan walks all 26
//   letters one per cycle through the single memory write port.
//   digraph beat: the position memory read into the position registers, then
//   the key table read, whose read register is the rsp register; the lookup
//   waits for a free rsp register before that read, and rsp_valid rises with it.
// Reset clears the used flags, fill pointer, complete flag and mode; the
// grid memories need no clearing. If rsp is stalled, the result holds and
// one more digraph beat is taken, then waits in lookup until rsp drains.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_top
   import pfd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_wdata
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   // controller
   pfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_payload.cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // datapath
   pfd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

   // checks
   a_read_needs_table: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.table_read || dp_cmd.pos_read) |-> dp_status.table_complete)
      else $error("digraph lookup before the key table is complete");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(dp_cmd.place_key && dp_cmd.fill_step))
      else $error("key placement and finish scan write together");

   a_frozen_table: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.fill_step || dp_cmd.place_key) |-> !dp_status.table_complete)
      else $error("write to a complete key table");

   a_complete_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(dp_status.table_complete) |-> $past(dp_cmd.fill_step))
      else $error("table marked complete outside the finish scan");

endmodule

// ----- tb/playfair_digraph_cipher_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_top_tb
// Builds one random key grid through key and finish beats, then sends digraph
// beats in both modes. Every beat is mirrored in a local model of the grid,
// and each rsp beat is checked against the oldest predicted letter pair.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_top_tb;
   import pfd_pkg::*;

   localparam logic [1:0] CMD_SPARE     = 2'd3;
   localparam int         SETTLE_CYCLES = 40;
   localparam int         LONG_HOLD     = 150;
   localparam int         QUIET_LIMIT   = 1000;
   localparam int         PHASE_BEATS   = 150;

   typedef enum logic [2:0] {
      OP_BEAT,
      OP_CSR,
      OP_DRAIN,
      OP_HOLD,
      OP_CALM
   } plan_kind_type;

   typedef struct {
      plan_kind_type   kind;
      req_payload_type beat;
      logic            mode;
   } plan_op_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic            csr_wdata = 1'b0;

   // stimulus plan and predicted letter pairs
   plan_op_type     beat_plan[$];
   rsp_payload_type pending_pairs[$];

   // local copy of the key grid
   logic [4:0] grid_letters [PLACES];
   int         letter_place [LETTERS];
   bit         letter_taken [LETTERS];
   int         grid_fill;
   bit         grid_done;
   bit         decrypt_sel;

   int  gap_cycles;
   int  settle_cycles;
   bit  draining;
   bit  calm;
   int  hold_request;
   int  hold_seen;
   int  stall_cycles;
   int  quiet_cycles;
   int  error_count;

   playfair_digraph_cipher_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // put a letter in the next free place of the grid
   task automatic grid_place(input int letter);
      if (grid_fill < PLACES) begin
         grid_letters[grid_fill] = 5'(letter);
         letter_place[letter]    = grid_fill;
         letter_taken[letter]    = 1'b1;
         grid_fill++;
      end
   endtask

   // track one accepted beat and queue the pair it yields
   task automatic cipher_absorb(input req_payload_type beat);
      int              a, b, shift, ra, ca, rb, cb, ta, tb;
      rsp_payload_type pair;
      case (beat.cmd)
         CMD_KEY: begin
            a = int'(beat.first_letter);
            if (!grid_done && a < LETTERS && a != int'(LETTER_J) && !letter_taken[a])
               grid_place(a);
         end
         CMD_FINISH: begin
            if (!grid_done) begin
               for (int k = 0; k < LETTERS; k++)
                  if (k != int'(LETTER_J) && !letter_taken[k]) grid_place(k);
               grid_done = 1'b1;
            end
         end
         CMD_PAIR: begin
            a = int'(beat.first_letter);
            b = int'(beat.second_letter);
            if (grid_done && a < LETTERS && b < LETTERS) begin
               if (a == int'(LETTER_J)) a = int'(LETTER_I);
               if (b == int'(LETTER_J)) b = int'(LETTER_I);
               shift = decrypt_sel ? GRID - 1 : 1;
               ra = letter_place[a] / GRID;
               ca = letter_place[a] % GRID;
               rb = letter_place[b] / GRID;
               cb = letter_place[b] % GRID;
               if (ra == rb) begin
                  ta = ra * GRID + (ca + shift) % GRID;
                  tb = rb * GRID + (cb + shift) % GRID;
               end else if (ca == cb) begin
                  ta = ((ra + shift) % GRID) * GRID + ca;
                  tb = ((rb + shift) % GRID) * GRID + cb;
               end else begin
                  ta = ra * GRID + cb;
                  tb = rb * GRID + ca;
               end
               pair.out_first  = grid_letters[ta];
               pair.out_second = grid_letters[tb];
               pending_pairs.push_back(pair);
            end
         end
         default: ;
      endcase
   endtask

   // driver: request and csr channels, fed from the plan
   always @(posedge clock) begin : driver
      plan_op_type op;
      logic        nxt_req_valid;
      logic        nxt_csr_valid;
      if (reset) begin
         req_valid     <= 1'b0;
         csr_valid     <= 1'b0;
         gap_cycles    = 0;
         settle_cycles = 0;
         draining      = 1'b0;
      end else begin
         nxt_req_valid = req_valid;
         nxt_csr_valid = csr_valid;
         if (req_valid && req_ready) begin
            cipher_absorb(req_payload);
            nxt_req_valid = 1'b0;
            if (!calm && $urandom_range(0, 7) == 0) gap_cycles = $urandom_range(1, 16);
         end
         if (csr_valid && csr_ready) begin
            decrypt_sel   = csr_wdata;
            nxt_csr_valid = 1'b0;
         end
         if (!nxt_req_valid && !nxt_csr_valid) begin
            if (gap_cycles > 0) begin
               gap_cycles--;
            end else if (draining) begin
               // wait for the last pair, then let any fill pass finish
               if (pending_pairs.size() != 0) begin
                  settle_cycles = 0;
               end else if (settle_cycles < SETTLE_CYCLES) begin
                  settle_cycles++;
               end else begin
                  settle_cycles = 0;
                  draining      = 1'b0;
               end
            end else if (beat_plan.size() != 0) begin
               op = beat_plan.pop_front();
               case (op.kind)
                  OP_BEAT: begin
                     nxt_req_valid = 1'b1;
                     req_payload   <= op.beat;
                  end
                  OP_CSR: begin
                     nxt_csr_valid = 1'b1;
                     csr_wdata     <= op.mode;
                  end
                  OP_DRAIN: draining = 1'b1;
                  OP_HOLD:  hold_request++;
                  OP_CALM:  calm = 1'b1;
                  default: ;
               endcase
            end
         end
         req_valid <= nxt_req_valid;
         csr_valid <= nxt_csr_valid;
      end
   end

   // monitor: check each rsp beat, drive rsp_ready with stalls
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_ready    <= 1'b0;
         stall_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_pairs.size() == 0) begin
               $display("%0t: unexpected rsp beat, expected none, actual %0d %0d",
                        $time, rsp_payload.out_first, rsp_payload.out_second);
               error_count++;
            end else begin
               want = pending_pairs.pop_front();
               if (rsp_payload.out_first !== want.out_first) begin
                  $display("%0t: out_first mismatch, expected %0d, actual %0d",
                           $time, want.out_first, rsp_payload.out_first);
                  error_count++;
               end
               if (rsp_payload.out_second !== want.out_second) begin
                  $display("%0t: out_second mismatch, expected %0d, actual %0d",
                           $time, want.out_second, rsp_payload.out_second);
                  error_count++;
               end
            end
         end
         if (hold_seen != hold_request) begin
            hold_seen    = hold_request;
            stall_cycles = LONG_HOLD;
         end
         if (stall_cycles > 0) begin
            stall_cycles--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_cycles = $urandom_range(0, 15);
            rsp_ready    <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("** playfair_digraph_cipher_top: FAILED **");
      $finish;
   end

   task automatic plan_beat(input logic [1:0] cmd, input int a, input int b);
      plan_op_type op;
      op.kind                 = OP_BEAT;
      op.beat.cmd             = cmd;
      op.beat.first_letter    = 5'(a);
      op.beat.second_letter   = 5'(b);
      op.mode                 = 1'b0;
      beat_plan.push_back(op);
   endtask

   task automatic plan_mark(input plan_kind_type kind, input logic mode);
      plan_op_type op;
      op.kind = kind;
      op.beat = '0;
      op.mode = mode;
      beat_plan.push_back(op);
   endtask

   // mode change only once the block has gone quiet
   task automatic plan_mode(input logic mode);
      plan_mark(OP_DRAIN, 1'b0);
      plan_mark(OP_CSR, mode);
   endtask

   initial begin : stimulus
      int sel;
      quiet_cycles = 0;
      error_count  = 0;
      hold_request = 0;
      hold_seen    = 0;
      calm         = 1'b0;
      grid_fill    = 0;
      grid_done    = 1'b0;
      decrypt_sel  = 1'b0;
      foreach (letter_taken[k]) letter_taken[k] = 1'b0;

      // before the grid is complete: pair gives nothing, bad keys ignored
      plan_mode(1'b1);
      plan_beat(CMD_PAIR, 0, 25);
      plan_beat(CMD_SPARE, 3, 4);
      plan_beat(CMD_KEY, int'(LETTER_J), 0);
      plan_beat(CMD_KEY, 26, 0);
      plan_beat(CMD_KEY, 31, 0);

      // random key word, repeats and out of range letters included
      sel = $urandom_range(0, 40);
      for (int i = 0; i < sel; i++) plan_beat(CMD_KEY, $urandom_range(0, 31), 0);
      plan_beat(CMD_KEY, 25, 31);
      plan_beat(CMD_FINISH, 0, 0);
      plan_beat(CMD_FINISH, 7, 7);
      plan_beat(CMD_KEY, $urandom_range(0, 25), 0);

      // letter extremes, j folding and doubled letters
      plan_mode(1'b0);
      plan_beat(CMD_PAIR, 0, 25);
      plan_beat(CMD_PAIR, 25, 0);
      plan_beat(CMD_PAIR, int'(LETTER_J), int'(LETTER_J));
      plan_beat(CMD_PAIR, int'(LETTER_J), int'(LETTER_I));
      plan_beat(CMD_PAIR, int'(LETTER_I), int'(LETTER_J));
      plan_beat(CMD_PAIR, 25, 25);
      plan_beat(CMD_PAIR, 26, 0);
      plan_beat(CMD_PAIR, 0, 31);
      plan_beat(CMD_PAIR, 31, 31);
      plan_beat(CMD_SPARE, 31, 31);

      // random phases, mode toggling between them
      for (int p = 0; p < 6; p++) begin
         plan_mode(p % 2 == 0);
         if (p == 2) plan_mark(OP_HOLD, 1'b0);
         if (p == 5) plan_mark(OP_CALM, 1'b0);
         for (int i = 0; i < PHASE_BEATS; i++) begin
            if (p == 3 && i == PHASE_BEATS / 2) plan_mark(OP_DRAIN, 1'b0);
            sel = $urandom_range(0, 99);
            if (sel < 85) begin
               sel = $urandom_range(0, 25);
               plan_beat(CMD_PAIR, sel,
                         ($urandom_range(0, 9) == 0) ? sel : $urandom_range(0, 25));
            end else begin
               plan_beat(2'($urandom_range(0, 3)), $urandom_range(0, 31),
                         $urandom_range(0, 31));
            end
         end
      end

      // reset, then wait for the plan to run out
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (beat_plan.size() != 0 || req_valid || csr_valid || draining ||
             pending_pairs.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_pairs.size() != 0) begin
         $display("%0t: %0d pairs never came out", $time, pending_pairs.size());
         error_count++;
      end

      if (error_count == 0) begin
         $display("** playfair_digraph_cipher_top: PASSED **");
      end else begin
         $display("** playfair_digraph_cipher_top: FAILED **");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/pfd_pkg.sv
rtl/pfd_ctrl.sv
rtl/pfd_datapath.sv
rtl/playfair_digraph_cipher_top.sv
tb/playfair_digraph_cipher_top_tb.sv
